// File: hdl/bmg_pkg.sv
// Shared constants and types for the Box-Muller Gaussian generator.
package bmg_pkg;

  localparam int UNIFORM_BITS_DEF = 32;
  localparam int IN_W = 32;
  localparam int CFG_W = 32;
  localparam int SAMPLE_W = 40;
  localparam int LOG_FRAC = 32;
  localparam int TRIG_LAT = 12;

  localparam logic [CFG_W-1:0] MEAN_RESET = 32'd0;
  localparam logic [CFG_W-1:0] STD_DEV_RESET = 32'd65536;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;
  localparam logic [33:0] PI_Q32 = 34'h3_243F_6A89;

  typedef enum logic [0:0] {
    REG_MEAN    = 1'b0,
    REG_STD_DEV = 1'b1
  } bmg_reg_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } bmg_quad_t;

  // One request in the Horner chain: angle, its square, sine and cosine partials.
  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] ps;
    logic [30:0] pc;
    bmg_quad_t   quad;
    logic        swap;
  } bmg_horner_t;

  // Signed trig results, Q.30 magnitude plus sign.
  typedef struct packed {
    logic [30:0] cmag;
    logic        cneg;
    logic [30:0] smag;
    logic        sneg;
  } bmg_trig_t;

endpackage

// File: hdl/bmg_log.sv
// Log pipeline: normalize U+1, 32 squaring stages for log2, scale by 2*ln2.
module bmg_log #(
  parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS_DEF,
  parameter int LW = 38,
  parameter int TW = 39
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [bmg_pkg::IN_W-1:0] u,
  input  logic [bmg_pkg::IN_W-1:0] v,
  output logic                     out_valid,
  output logic [TW-1:0]            t,
  output logic [bmg_pkg::IN_W-1:0] v_out
);

  localparam int EW = LW - 32;
  localparam int NSQ = bmg_pkg::LOG_FRAC;
  localparam int PW = LW + 64;
  localparam logic [31:0] UMASK = (UNIFORM_BITS >= 32) ? 32'hFFFF_FFFF :
                                  32'((64'd1 << UNIFORM_BITS) - 64'd1);
  localparam logic [LW-1:0] LMAX = {LW'(UNIFORM_BITS)} << 32;

  // stage 0: m = U+1 and its leading one
  logic [32:0]   m_next;
  logic [EW-1:0] e_next;
  logic          val0;
  logic [32:0]   m0;
  logic [EW-1:0] e0;
  logic [31:0]   v0;

  assign m_next = {1'b0, u & UMASK} + 33'd1;

  always_comb begin
    e_next = '0;
    for (int i = 0; i < 33; i++) begin
      if (m_next[i]) e_next = EW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) val0 <= 1'b0;
    else if (adv) val0 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0 <= m_next;
      e0 <= e_next;
      v0 <= v;
    end
  end

  // stage 1: mantissa to Q1.31
  logic [63:0]   norm;
  logic          val1;
  logic [31:0]   f1;
  logic [EW-1:0] e1;
  logic [31:0]   v1;

  assign norm = ({31'd0, m0} << 31) >> e0;

  always_ff @(posedge clk) begin
    if (rst) val1 <= 1'b0;
    else if (adv) val1 <= val0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1 <= norm[31:0];
      e1 <= e0;
      v1 <= v0;
    end
  end

  // squaring stages, one fraction bit each
  logic [31:0]   sq_f  [NSQ];
  logic [31:0]   sq_fr [NSQ];
  logic [EW-1:0] sq_e  [NSQ];
  logic [31:0]   sq_v  [NSQ];
  logic          sq_val[NSQ];

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [31:0]   f_in;
    logic [31:0]   fr_in;
    logic [EW-1:0] e_in;
    logic [31:0]   v_in;
    logic          val_in;
    logic [63:0]   sq;
    logic [32:0]   f2;

    if (k == 0) begin : g_first
      assign f_in = f1;
      assign fr_in = '0;
      assign e_in = e1;
      assign v_in = v1;
      assign val_in = val1;
    end else begin : g_next
      assign f_in = sq_f[k-1];
      assign fr_in = sq_fr[k-1];
      assign e_in = sq_e[k-1];
      assign v_in = sq_v[k-1];
      assign val_in = sq_val[k-1];
    end

    assign sq = 64'(f_in) * 64'(f_in);
    assign f2 = sq[63:31];

    always_ff @(posedge clk) begin
      if (rst) sq_val[k] <= 1'b0;
      else if (adv) sq_val[k] <= val_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_f[k]  <= f2[32] ? f2[32:1] : f2[31:0];
        sq_fr[k] <= {fr_in[30:0], f2[32]};
        sq_e[k]  <= e_in;
        sq_v[k]  <= v_in;
      end
    end
  end

  // L = W - log2(m), Q.32
  logic          val_l;
  logic [LW-1:0] l_val;
  logic [31:0]   v_l;

  always_ff @(posedge clk) begin
    if (rst) val_l <= 1'b0;
    else if (adv) val_l <= sq_val[NSQ-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_val <= LMAX - {sq_e[NSQ-1], sq_fr[NSQ-1]};
      v_l   <= sq_v[NSQ-1];
    end
  end

  // partial products of L * ln2 in Q.64
  logic             val_p;
  logic [63:0]      p_ll;
  logic [63:0]      p_lh;
  logic [EW+31:0]   p_hl;
  logic [EW+31:0]   p_hh;
  logic [31:0]      v_p;

  always_ff @(posedge clk) begin
    if (rst) val_p <= 1'b0;
    else if (adv) val_p <= val_l;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ll <= 64'(l_val[31:0]) * 64'(bmg_pkg::LN2_Q64[31:0]);
      p_lh <= 64'(l_val[31:0]) * 64'(bmg_pkg::LN2_Q64[63:32]);
      p_hl <= (EW+32)'(l_val[LW-1:32]) * (EW+32)'(bmg_pkg::LN2_Q64[31:0]);
      p_hh <= (EW+32)'(l_val[LW-1:32]) * (EW+32)'(bmg_pkg::LN2_Q64[63:32]);
      v_p  <= v_l;
    end
  end

  // sum and take bits from 63 up: t = -2 ln u, Q.32
  logic [PW-1:0] total;

  assign total = PW'(p_ll) + (PW'(p_lh) << 32) + (PW'(p_hl) << 32) + (PW'(p_hh) << 64);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= val_p;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t     <= total[PW-1:63];
      v_out <= v_p;
    end
  end

endmodule

// File: hdl/bmg_sqrt.sv
// Integer square root of t<<16, one result bit per stage.
module bmg_sqrt #(
  parameter int TW = 39,
  parameter int SQ = 28
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [TW-1:0] t,
  output logic          out_valid,
  output logic [SQ-1:0] s
);

  localparam int NE = 2 * SQ;
  localparam int RW = SQ + 2;

  logic [SQ-1:0] root[SQ];
  logic [RW-1:0] rem [SQ];
  logic [NE-1:0] nsh [SQ];
  logic          val [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_step
    logic [SQ-1:0] root_in;
    logic [RW-1:0] rem_in;
    logic [NE-1:0] n_in;
    logic          val_in;
    logic [RW-1:0] rn;
    logic [RW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in = '0;
      assign n_in = NE'({t, 16'd0});
      assign val_in = in_valid;
    end else begin : g_next
      assign root_in = root[k-1];
      assign rem_in = rem[k-1];
      assign n_in = nsh[k-1];
      assign val_in = val[k-1];
    end

    assign rn = {rem_in[SQ-1:0], n_in[NE-1:NE-2]};
    assign trial = {root_in, 2'b01};
    assign take = rn >= trial;

    always_ff @(posedge clk) begin
      if (rst) val[k] <= 1'b0;
      else if (adv) val[k] <= val_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        root[k] <= {root_in[SQ-2:0], take};
        rem[k]  <= take ? rn - trial : rn;
        nsh[k]  <= n_in << 2;
      end
    end
  end

  assign out_valid = val[SQ-1];
  assign s = root[SQ-1];

endmodule

// File: hdl/bmg_horner.sv
// One Horner step for sine and cosine: 1 - x2*p/d; FINAL_SIN gives sine x*p.
module bmg_horner #(
  parameter int DIV_S = 6,
  parameter int DIV_C = 12,
  parameter bit FINAL_SIN = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  bmg_pkg::bmg_horner_t in_h,
  output logic                 out_valid,
  output bmg_pkg::bmg_horner_t out_h
);

  // floor(n/d) = (n*M) >> S, exact for n < 2^31
  localparam int SH_S = 31 + $clog2(DIV_S);
  localparam int SH_C = 31 + $clog2(DIV_C);
  localparam logic [32:0] M_S = 33'(((64'd1 << SH_S) + 64'(DIV_S) - 64'd1) / 64'(DIV_S));
  localparam logic [32:0] M_C = 33'(((64'd1 << SH_C) + 64'(DIV_C) - 64'd1) / 64'(DIV_C));

  logic [29:0]          op_s;
  logic [63:0]          prod_s;
  logic [63:0]          prod_c;
  logic                 mid_valid;
  bmg_pkg::bmg_horner_t mid;

  assign op_s = FINAL_SIN ? in_h.x : in_h.x2;
  assign prod_s = 64'(op_s) * 64'(in_h.ps);
  assign prod_c = 64'(in_h.x2) * 64'(in_h.pc);

  always_ff @(posedge clk) begin
    if (rst) mid_valid <= 1'b0;
    else if (adv) mid_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid.x    <= in_h.x;
      mid.x2   <= in_h.x2;
      mid.ps   <= prod_s[60:30];
      mid.pc   <= prod_c[60:30];
      mid.quad <= in_h.quad;
      mid.swap <= in_h.swap;
    end
  end

  logic [63:0] q_s;
  logic [63:0] q_c;

  assign q_s = (64'(mid.ps) * 64'(M_S)) >> SH_S;
  assign q_c = (64'(mid.pc) * 64'(M_C)) >> SH_C;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= mid_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_h.x    <= mid.x;
      out_h.x2   <= mid.x2;
      out_h.ps   <= FINAL_SIN ? mid.ps : bmg_pkg::ONE_Q30 - q_s[30:0];
      out_h.pc   <= bmg_pkg::ONE_Q30 - q_c[30:0];
      out_h.quad <= mid.quad;
      out_h.swap <= mid.swap;
    end
  end

endmodule

// File: hdl/bmg_trig.sv
// Angle reduction, sine and cosine series, quadrant signs, delay to the radius.
module bmg_trig #(
  parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS_DEF,
  parameter int SQ = 28
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [bmg_pkg::IN_W-1:0] v,
  output logic                     out_valid,
  output bmg_pkg::bmg_trig_t       trig
);

  localparam int VSHR = (UNIFORM_BITS >= 32) ? UNIFORM_BITS - 32 : 0;
  localparam int VSHL = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;
  localparam int PAD = SQ - bmg_pkg::TRIG_LAT;
  localparam int NH = 5;

  // stage A0: octant fold and x = a*pi/2 in Q.30
  logic [31:0]        p;
  logic               swap_n;
  logic [29:0]        a;
  logic [63:0]        xp;
  logic               val_a0;
  logic [29:0]        x0;
  bmg_pkg::bmg_quad_t quad0;
  logic               swap0;

  assign p = 32'((v >> VSHR) << VSHL);
  assign swap_n = p[29];
  assign a = swap_n ? 30'(bmg_pkg::ONE_Q30 - {1'b0, p[29:0]}) : p[29:0];
  assign xp = 64'(a) * 64'(bmg_pkg::PI_Q32);

  always_ff @(posedge clk) begin
    if (rst) val_a0 <= 1'b0;
    else if (adv) val_a0 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0    <= xp[62:33];
      quad0 <= bmg_pkg::bmg_quad_t'(p[31:30]);
      swap0 <= swap_n;
    end
  end

  // stage A1: x squared
  logic [59:0]          x2p;
  logic                 val_a1;
  bmg_pkg::bmg_horner_t h0;

  assign x2p = 60'(x0) * 60'(x0);

  always_ff @(posedge clk) begin
    if (rst) val_a1 <= 1'b0;
    else if (adv) val_a1 <= val_a0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h0.x    <= x0;
      h0.x2   <= x2p[59:30];
      h0.ps   <= bmg_pkg::ONE_Q30;
      h0.pc   <= bmg_pkg::ONE_Q30;
      h0.quad <= quad0;
      h0.swap <= swap0;
    end
  end

  // series: sine to x^9, cosine to x^10
  bmg_pkg::bmg_horner_t hs  [NH+1];
  logic                 hval[NH+1];

  assign hs[0] = h0;
  assign hval[0] = val_a1;

  bmg_horner #(.DIV_S(72), .DIV_C(90), .FINAL_SIN(1'b0)) u_h0 (
    .clk, .rst, .adv, .in_valid(hval[0]), .in_h(hs[0]), .out_valid(hval[1]), .out_h(hs[1])
  );
  bmg_horner #(.DIV_S(42), .DIV_C(56), .FINAL_SIN(1'b0)) u_h1 (
    .clk, .rst, .adv, .in_valid(hval[1]), .in_h(hs[1]), .out_valid(hval[2]), .out_h(hs[2])
  );
  bmg_horner #(.DIV_S(20), .DIV_C(30), .FINAL_SIN(1'b0)) u_h2 (
    .clk, .rst, .adv, .in_valid(hval[2]), .in_h(hs[2]), .out_valid(hval[3]), .out_h(hs[3])
  );
  bmg_horner #(.DIV_S(6), .DIV_C(12), .FINAL_SIN(1'b0)) u_h3 (
    .clk, .rst, .adv, .in_valid(hval[3]), .in_h(hs[3]), .out_valid(hval[4]), .out_h(hs[4])
  );
  // last step: sine is x*p, cosine divides by 2
  bmg_horner #(.DIV_S(1), .DIV_C(2), .FINAL_SIN(1'b1)) u_h4 (
    .clk, .rst, .adv, .in_valid(hval[4]), .in_h(hs[4]), .out_valid(hval[5]), .out_h(hs[5])
  );

  // quadrant signs and order
  bmg_pkg::bmg_horner_t hl;
  logic [30:0]          c0;
  logic [30:0]          s0;
  bmg_pkg::bmg_trig_t   mapped;

  assign hl = hs[NH];

  always_comb begin
    c0 = hl.swap ? hl.ps : hl.pc;
    s0 = hl.swap ? hl.pc : hl.ps;
    mapped = '0;
    unique case (hl.quad)
      bmg_pkg::QUAD_0: mapped = '{cmag: c0, cneg: 1'b0, smag: s0, sneg: 1'b0};
      bmg_pkg::QUAD_1: mapped = '{cmag: s0, cneg: 1'b1, smag: c0, sneg: 1'b0};
      bmg_pkg::QUAD_2: mapped = '{cmag: c0, cneg: 1'b1, smag: s0, sneg: 1'b1};
      bmg_pkg::QUAD_3: mapped = '{cmag: s0, cneg: 1'b0, smag: c0, sneg: 1'b1};
    endcase
  end

  // delay line to line up with the square root
  bmg_pkg::bmg_trig_t pad_d  [PAD];
  logic               pad_val[PAD];

  for (genvar k = 0; k < PAD; k++) begin : g_pad
    bmg_pkg::bmg_trig_t d_in;
    logic               val_in;

    if (k == 0) begin : g_first
      assign d_in = mapped;
      assign val_in = hval[NH];
    end else begin : g_next
      assign d_in = pad_d[k-1];
      assign val_in = pad_val[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) pad_val[k] <= 1'b0;
      else if (adv) pad_val[k] <= val_in;
    end

    always_ff @(posedge clk) begin
      if (adv) pad_d[k] <= d_in;
    end
  end

  assign out_valid = pad_val[PAD-1];
  assign trig = pad_d[PAD-1];

endmodule

// File: hdl/bmg_out.sv
// Scaling by radius and std_dev, mean offset, saturation, two-result output buffer.
module bmg_out #(
  parameter int SQ = 28
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [SQ-1:0]                s,
  input  bmg_pkg::bmg_trig_t           trig,
  input  logic [bmg_pkg::CFG_W-1:0]    mean,
  input  logic [bmg_pkg::CFG_W-1:0]    std_dev,
  input  logic                         m_axis_tready,
  output logic                         adv,
  output logic                         m_axis_tvalid,
  output logic [bmg_pkg::SAMPLE_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);

  localparam int SW = bmg_pkg::SAMPLE_W;
  localparam int PW = SQ + 8;
  localparam int VW = (SQ + 10 > SW + 1) ? SQ + 10 : SW + 1;
  localparam logic signed [VW-1:0] SMAX = signed'(VW'((64'd1 << (SW - 1)) - 64'd1));
  localparam logic signed [VW-1:0] SMIN = ~SMAX;

  function automatic logic [SW-1:0] sat_sum(input logic signed [VW-1:0] base,
                                            input logic [PW-1:0] mag, input logic neg);
    logic signed [VW-1:0] m;
    logic signed [VW-1:0] val;
    m = signed'(VW'(mag));
    val = neg ? base - m : base + m;
    if (val > SMAX) val = SMAX;
    else if (val < SMIN) val = SMIN;
    return val[SW-1:0];
  endfunction

  logic buf_valid;
  logic phase;

  // whole pipeline moves when the buffer is empty or its second result leaves
  assign adv = !buf_valid || (phase && m_axis_tready);

  // stage O1: s * |trig|
  logic [63:0]   zc_p;
  logic [63:0]   zs_p;
  logic          v1;
  logic [SQ-1:0] zc;
  logic [SQ-1:0] zs;
  logic          cneg1;
  logic          sneg1;

  assign zc_p = 64'(s) * 64'(trig.cmag);
  assign zs_p = 64'(s) * 64'(trig.smag);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zc    <= zc_p[SQ+29:30];
      zs    <= zs_p[SQ+29:30];
      cneg1 <= trig.cneg;
      sneg1 <= trig.sneg;
    end
  end

  // stage O2: times std_dev
  logic [63:0]   pc_p;
  logic [63:0]   ps_p;
  logic          v2;
  logic [PW-1:0] prod_c;
  logic [PW-1:0] prod_s;
  logic          cneg2;
  logic          sneg2;

  assign pc_p = 64'(zc) * 64'(std_dev);
  assign ps_p = 64'(zs) * 64'(std_dev);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_c <= pc_p[PW+23:24];
      prod_s <= ps_p[PW+23:24];
      cneg2  <= cneg1;
      sneg2  <= sneg1;
    end
  end

  // stage O3: mean offset into the output buffer
  logic signed [VW-1:0] base;
  logic [SW-1:0]        samp_c;
  logic [SW-1:0]        samp_s;

  assign base = signed'(VW'(signed'(mean)));

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      phase <= 1'b0;
    end else if (adv) begin
      buf_valid <= v2;
      phase <= 1'b0;
    end else if (buf_valid && !phase && m_axis_tready) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      samp_c <= sat_sum(base, prod_c, cneg2);
      samp_s <= sat_sum(base, prod_s, sneg2);
    end
  end

  assign m_axis_tvalid = buf_valid;
  assign m_axis_tdata = phase ? samp_s : samp_c;
  assign m_axis_tlast = phase;

endmodule

// File: hdl/box_muller_gaussian.sv
// Box-Muller Gaussian generator top level: config registers and pipeline wiring.
//
// Each request carries two uniforms, u in tdata[31:0] and v in tdata[63:32], and
// produces two Q24.16 samples: mean + std_dev*sqrt(-2 ln u)*cos(2*pi*v), then the
// sine result, which is marked with tlast. At most one request is taken per pair
// of results sent, as the single output port carries both results of a pair;
// the datapath itself is fully pipelined and accepts back to back. A request
// passes the log (normalize, 32 squarings, ln2 scaling), then the bit-serial
// square root of SQ = (LW + 18) / 2 bits, LW = clog2(UNIFORM_BITS + 1) + 32
// (SQ = 28 at 32 bits), with the angle and series stages running beside it,
// and last scaling and the mean offset. The whole pipeline holds when the
// output buffer is blocked; nothing is lost or repeated. mean and std_dev are
// written through cfg_we, cfg_index, cfg_data and must only change while the
// block is idle.
module box_muller_gaussian #(
  parameter int UNIFORM_BITS = bmg_pkg::UNIFORM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] u_uniform, [63:32] v_uniform
  input  logic [2*bmg_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [39:0] sample
  output logic [bmg_pkg::SAMPLE_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [bmg_pkg::CFG_W-1:0]    cfg_data
);

  localparam int LW = $clog2(UNIFORM_BITS + 1) + 32;  // L = W - log2 m, Q.32
  localparam int TW = LW + 1;                         // t = -2 ln u, Q.32
  localparam int SQ = (TW + 16 + 1) / 2;              // root bits of t<<16

  // configuration registers
  logic [bmg_pkg::CFG_W-1:0] mean;
  logic [bmg_pkg::CFG_W-1:0] std_dev;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean <= bmg_pkg::MEAN_RESET;
      std_dev <= bmg_pkg::STD_DEV_RESET;
    end else if (cfg_we) begin
      if (cfg_index == bmg_pkg::REG_MEAN) mean <= cfg_data;
      if (cfg_index == bmg_pkg::REG_STD_DEV) std_dev <= cfg_data;
    end
  end

  // global advance from the output buffer
  logic adv;

  assign s_axis_tready = adv;

  // log: t = -2 ln u, v travels alongside
  logic                     log_valid;
  logic [TW-1:0]            t;
  logic [bmg_pkg::IN_W-1:0] v_log;

  bmg_log #(.UNIFORM_BITS(UNIFORM_BITS), .LW(LW), .TW(TW)) u_log (
    .clk, .rst, .adv,
    .in_valid (s_axis_tvalid),
    .u        (s_axis_tdata[bmg_pkg::IN_W-1:0]),
    .v        (s_axis_tdata[2*bmg_pkg::IN_W-1:bmg_pkg::IN_W]),
    .out_valid(log_valid),
    .t,
    .v_out    (v_log)
  );

  // radius s, Q.24
  logic          sqrt_valid;
  logic [SQ-1:0] s;

  bmg_sqrt #(.TW(TW), .SQ(SQ)) u_sqrt (
    .clk, .rst, .adv,
    .in_valid (log_valid),
    .t,
    .out_valid(sqrt_valid),
    .s
  );

  // cos and sin of 2*pi*v, same latency as the root
  logic               trig_valid;
  bmg_pkg::bmg_trig_t trig;

  bmg_trig #(.UNIFORM_BITS(UNIFORM_BITS), .SQ(SQ)) u_trig (
    .clk, .rst, .adv,
    .in_valid (log_valid),
    .v        (v_log),
    .out_valid(trig_valid),
    .trig
  );

  // scaling, offset and result buffer
  bmg_out #(.SQ(SQ)) u_out (
    .clk, .rst,
    .in_valid(sqrt_valid),
    .s,
    .trig,
    .mean,
    .std_dev,
    .m_axis_tready,
    .adv,
    .m_axis_tvalid,
    .m_axis_tdata,
    .m_axis_tlast
  );

  // radius and angle paths must stay in lockstep
  a_align: assert property (@(posedge clk) disable iff (rst) trig_valid == sqrt_valid)
    else $error("radius and angle pipelines out of step");

  // a cosine result taken is followed by its sine result
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("sine result missing after cosine result");

  // a new request enters only while the buffer is empty or its last result leaves
  a_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast && m_axis_tready)
    else $error("pipeline advanced over a pending result");

endmodule

// File: verif/box_muller_gaussian_test.sv
// Testbench for the Box-Muller Gaussian generator: directed and random requests.
`timescale 1ns / 1ps

module box_muller_gaussian_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_REQUESTS = 1400;

  // One predicted sample: 40-bit value plus the tlast flag.
  typedef struct {
    logic [bmg_pkg::SAMPLE_W-1:0] sample;
    logic                         last;
  } gauss_sample_t;

  // Predictor state: copies of the two registers.
  logic [bmg_pkg::CFG_W-1:0] mean_reg;
  logic [bmg_pkg::CFG_W-1:0] sigma_reg;

  // sqrt(-2 ln u) in Q.24, u = (U+1)/2^32
  function automatic logic [63:0] radius_q24(input logic [31:0] uval);
    logic [63:0] m, f, frac, log2m, lfix, t, n, res, bit_q;
    logic [127:0] wide;
    int e;
    m = {32'd0, uval} + 64'd1;
    e = 0;
    while (e < 63 && (m >> (e + 1)) != 0) e++;
    f = (e >= 31) ? (m >> (e - 31)) : (m << (31 - e));
    frac = 0;
    for (int i = 0; i < 32; i++) begin
      f = (f * f) >> 31;
      frac = frac << 1;
      if (f >= (64'd1 << 32)) begin
        f = f >> 1;
        frac = frac | 64'd1;
      end
    end
    log2m = (64'(e) << 32) + frac;
    lfix = (64'd32 << 32) - log2m;
    wide = {64'd0, lfix} * {64'd0, bmg_pkg::LN2_Q64};
    t = wide[126:63];
    n = t << 16;
    res = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > n) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (n >= res + bit_q) begin
        n = n - (res + bit_q);
        res = (res >> 1) + bit_q;
      end else begin
        res = res >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return res;
  endfunction

  // Scale one trig magnitude, apply sign, add the mean, saturate.
  function automatic logic [bmg_pkg::SAMPLE_W-1:0] scale_sample(input logic [63:0] s24,
                                                                input logic [63:0] mag,
                                                                input logic neg);
    logic [63:0] z24, prod;
    logic signed [65:0] val;
    z24 = (s24 * mag) >> 30;
    prod = (z24 * {32'd0, sigma_reg}) >> 24;
    val = 66'(signed'(mean_reg));
    val = neg ? val - $signed({2'b0, prod}) : val + $signed({2'b0, prod});
    if (val > 66'sd549755813887) val = 66'sd549755813887;
    if (val < -66'sd549755813888) val = -66'sd549755813888;
    return val[bmg_pkg::SAMPLE_W-1:0];
  endfunction

  // Both samples of a pair: cosine first, then sine.
  task automatic predict_pair(input logic [31:0] uval, input logic [31:0] vval,
                              output gauss_sample_t pair [2]);
    logic [63:0] s24, one, f30, a, x, x2, p, sn, cs, c0, s0, cm, sm;
    logic cn, sg, swap;
    bmg_pkg::bmg_quad_t quad;
    one = 64'd1 << 30;
    s24 = radius_q24(uval);
    quad = bmg_pkg::bmg_quad_t'(vval[31:30]);
    f30 = {34'd0, vval[29:0]};
    swap = f30 >= (one >> 1);
    a = swap ? one - f30 : f30;
    x = (a * {30'd0, bmg_pkg::PI_Q32}) >> 33;
    x2 = (x * x) >> 30;
    p = one - x2 / 72;
    p = one - ((x2 * p) >> 30) / 42;
    p = one - ((x2 * p) >> 30) / 20;
    p = one - ((x2 * p) >> 30) / 6;
    sn = (x * p) >> 30;
    p = one - x2 / 90;
    p = one - ((x2 * p) >> 30) / 56;
    p = one - ((x2 * p) >> 30) / 30;
    p = one - ((x2 * p) >> 30) / 12;
    cs = one - ((x2 * p) >> 30) / 2;
    c0 = swap ? sn : cs;
    s0 = swap ? cs : sn;
    case (quad)
      bmg_pkg::QUAD_0: begin cm = c0; cn = 0; sm = s0; sg = 0; end
      bmg_pkg::QUAD_1: begin cm = s0; cn = 1; sm = c0; sg = 0; end
      bmg_pkg::QUAD_2: begin cm = c0; cn = 1; sm = s0; sg = 1; end
      default: begin cm = s0; cn = 0; sm = c0; sg = 1; end
    endcase
    pair[0].sample = scale_sample(s24, cm, cn);
    pair[0].last = 1'b0;
    pair[1].sample = scale_sample(s24, sm, sg);
    pair[1].last = 1'b1;
  endtask

  // Scoreboard: queue of pending samples and the mismatch count.
  class sample_scoreboard;
    gauss_sample_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(gauss_sample_t pair [2]);
      pending.push_back(pair[0]);
      pending.push_back(pair[1]);
    endfunction

    function void check_sample(logic [bmg_pkg::SAMPLE_W-1:0] sample, logic last);
      gauss_sample_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample %h last %b", sample, last);
        return;
      end
      want = pending.pop_front();
      if (want.sample !== sample || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("sample: expected %h last %b, got %h last %b",
                   want.sample, want.last, sample, last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [bmg_pkg::SAMPLE_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [bmg_pkg::CFG_W-1:0] cfg_data = '0;

  sample_scoreboard board = new();
  bit idle_off = 0;
  bit sink_pause_on = 1;
  int quiet_cycles = 0;

  box_muller_gaussian dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Sample results at the rising edge; watchdog counts cycles with no transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) board.check_sample(m_axis_tdata, m_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("box_muller_gaussian: mismatch");
        $finish;
      end
    end
  end

  // Receiver: ready drops in random bursts, none near the end.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (!idle_off && sink_pause_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 6);
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1;
    end
  end

  // Drive one request and hold it until accepted; predict when driven, queue the prediction at acceptance.
  task automatic send_request(input logic [31:0] uval, input logic [31:0] vval);
    gauss_sample_t pair [2];
    if (!idle_off && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tdata <= {vval, uval};
    s_axis_tvalid <= 1;
    predict_pair(uval, vval, pair);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_request(pair);
    @(negedge clk);
  endtask

  // Wait until every pending sample is back, then let the pipeline settle.
  task automatic drain_all();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input bmg_pkg::bmg_reg_t idx,
                           input logic [bmg_pkg::CFG_W-1:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == bmg_pkg::REG_MEAN) mean_reg = value;
    else sigma_reg = value;
    @(negedge clk);
  endtask

  // Random u: mostly uniform, sometimes the extremes or values within 255 of them.
  function automatic logic [31:0] pick_uniform();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Random v: mostly uniform, sometimes at octant edges to exercise quadrant and swap boundaries.
  function automatic logic [31:0] pick_angle();
    logic [31:0] edge_pt;
    if ($urandom_range(0, 4) == 0) begin
      edge_pt = $urandom_range(0, 7) << 29;
      return edge_pt + $urandom_range(0, 2) - 1;
    end
    return $urandom;
  endfunction

  initial begin
    logic [bmg_pkg::CFG_W-1:0] means [4];
    logic [bmg_pkg::CFG_W-1:0] sigmas [4];
    mean_reg = bmg_pkg::MEAN_RESET;
    sigma_reg = bmg_pkg::STD_DEV_RESET;
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: reset config, then extremes of u and v over every quadrant and swap.
    send_request(32'hFFFF_FFFF, 32'h1234_5678);   // u = 1: both samples equal mean
    send_request(32'h0, 32'h0);                   // largest radius, zero angle
    send_request(32'h0, 32'hFFFF_FFFF);
    send_request(32'h0000_0001, 32'h4000_0000);
    send_request(32'h8000_0000, 32'h8000_0000);
    send_request(32'h7FFF_FFFF, 32'hC000_0000);
    send_request(32'hFFFF_FFFE, 32'h2000_0000);   // octant boundary, swap begins
    send_request(32'h5555_5555, 32'h1FFF_FFFF);
    send_request(32'hAAAA_AAAA, 32'h6000_0000);
    send_request(32'h0000_FFFF, 32'hA000_0001);
    send_request(32'hFFFF_0000, 32'hE000_0000);
    send_request(32'h1, 32'h3FFF_FFFF);

    // Sender holds off until everything is back.
    drain_all();
    write_reg(bmg_pkg::REG_MEAN, 32'h8000_0000);
    write_reg(bmg_pkg::REG_STD_DEV, 32'hFFFF_FFFF);
    send_request(32'h0, 32'h0);
    send_request(32'h0, 32'h8000_0000);
    send_request(32'hFFFF_FFFF, 32'h5A5A_5A5A);
    drain_all();
    write_reg(bmg_pkg::REG_MEAN, 32'h7FFF_FFFF);
    send_request(32'h0, 32'h0);
    send_request(32'h0, 32'h4000_0000);
    send_request(32'h0, 32'hC000_0000);

    // Random phases over several register settings, extremes included.
    means = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF3_8000};
    sigmas = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0002_8000};
    for (int ph = 0; ph < 5; ph++) begin
      drain_all();
      if (ph < 4) begin
        write_reg(bmg_pkg::REG_MEAN, means[ph]);
        write_reg(bmg_pkg::REG_STD_DEV, sigmas[ph]);
      end else begin
        write_reg(bmg_pkg::REG_MEAN, $urandom);
        write_reg(bmg_pkg::REG_STD_DEV, $urandom);
        idle_off = 1;   // last stretch runs at full rate
      end
      repeat (RANDOM_REQUESTS / 5) send_request(pick_uniform(), pick_angle());
    end

    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0)
      $display("box_muller_gaussian: match");
    else
      $display("box_muller_gaussian: mismatch");
    $finish;
  end

endmodule

// File: files.f
hdl/bmg_pkg.sv
hdl/bmg_log.sv
hdl/bmg_sqrt.sv
hdl/bmg_horner.sv
hdl/bmg_trig.sv
hdl/bmg_out.sv
hdl/box_muller_gaussian.sv
verif/box_muller_gaussian_test.sv
